// ----- rtl/wildcard_name_matcher_macros.svh -----
// assertion macros shared by the wildcard name matcher
`ifndef WILDCARD_NAME_MATCHER_MACROS_SVH
`define WILDCARD_NAME_MATCHER_MACROS_SVH

// condition that must hold at every rising clock edge out of reset
`define WNM_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error(msg);

// implication checked in the same cycle
`define WNM_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

// ----- rtl/wnm_pkg.sv -----
// shared constants and types for the wildcard name matcher
`timescale 1ns / 1ps

package wnm_pkg;

    // pattern store depth and derived widths
    localparam int MAX_PATTERN = 32;
    localparam int POS_W       = MAX_PATTERN + 1;
    localparam int LEN_W       = $clog2(MAX_PATTERN + 1);

    // wildcard bytes
    localparam logic [7:0] ANY_ONE = 8'd63;
    localparam logic [7:0] ANY_RUN = 8'd42;

    // command codes
    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_NAME = 1'b1;

    // one result beat
    typedef struct packed {
        logic matched;
        logic pattern_overflow;
    } t_result;

    // what a cell hands to its right neighbor and to the run closure
    typedef struct packed {
        logic adv;   // position advances past this cell
        logic nxt;   // raw next-active bit for this cell's position
        logic star;  // this cell holds an any-run byte inside the pattern
    } t_cell_link;

endpackage

// ----- rtl/wnm_cell.sv -----
// one pattern cell: stores a pattern byte and steps its active position
`timescale 1ns / 1ps

module wnm_cell (
    input  logic                i_clk,
    input  logic                i_wr,
    input  logic [7:0]          i_ch,
    input  logic                i_in_use,
    input  logic                i_cur,
    input  logic                i_adv,
    output wnm_pkg::t_cell_link o_link
);
    import wnm_pkg::*;

    logic [7:0] r_byte;
    logic       is_star;
    logic       hit;

    // pattern byte storage, written once per load beat
    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_byte <= i_ch;
        end
    end

    // any-run self loop, or single byte compare moving one position on
    assign is_star = i_in_use && (r_byte == ANY_RUN);
    assign hit     = i_in_use && i_cur && !is_star
                     && ((r_byte == ANY_ONE) || (r_byte == i_ch));

    assign o_link.adv  = hit;
    assign o_link.nxt  = i_adv | (i_cur & is_star);
    assign o_link.star = is_star;

endmodule

// ----- rtl/wnm_out_skid.sv -----
// two-entry output stage: result register plus skid register
`timescale 1ns / 1ps

module wnm_out_skid (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  wnm_pkg::t_result i_data,
    output logic             o_ready,
    output logic             o_valid,
    input  logic             i_ready,
    output wnm_pkg::t_result o_data
);
    import wnm_pkg::*;

    logic    r_out_valid;
    logic    n_out_valid;
    t_result r_out;
    t_result n_out;
    logic    r_skid_valid;
    logic    n_skid_valid;
    t_result r_skid;
    t_result n_skid;
    logic    out_free;

    assign out_free = !r_out_valid || i_ready;

    // refill the output from the skid first, then from the new beat
    always_comb begin
        n_out_valid  = r_out_valid;
        n_out        = r_out;
        n_skid_valid = r_skid_valid;
        n_skid       = r_skid;
        if (out_free) begin
            if (r_skid_valid) begin
                n_out_valid  = 1'b1;
                n_out        = r_skid;
                n_skid_valid = i_push;
                n_skid       = i_data;
            end else begin
                n_out_valid  = i_push;
                n_out        = i_data;
            end
        end else if (i_push) begin
            n_skid_valid = 1'b1;
            n_skid       = i_data;
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        r_out  <= n_out;
        r_skid <= n_skid;
    end

    assign o_ready = !r_skid_valid;
    assign o_valid = r_out_valid;
    assign o_data  = r_out;

endmodule

// ----- rtl/wildcard_name_matcher.sv -----
// Wildcard name matcher: a pattern is loaded one byte per beat (cmd 0) into a row
// of 32 cells, '?' matching any one byte and '*' any run including an empty one;
// bytes past the 32nd are dropped and flagged. Name bytes (cmd 1) then stream in
// at one beat per clock, and the beat with last set yields one result beat,
// carrying the verdict and the overflow flag, via the output or skid register.
// In each beat each cell compares its byte and hands its advance bit to the next
// cell, and a single 33-bit add closes active positions over runs of '*' cells in
// the same cycle. Input stalls only when two result beats wait at the output.
`timescale 1ns / 1ps
`include "wildcard_name_matcher_macros.svh"

module wildcard_name_matcher (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic       i_cmd,
    input  logic [7:0] i_ch,
    input  logic       i_last,
    output logic       o_valid,
    input  logic       i_ready,
    output logic       o_matched,
    output logic       o_pattern_overflow
);
    import wnm_pkg::*;

    logic [LEN_W-1:0] r_len;
    logic [LEN_W-1:0] n_len;
    logic             r_ovf;
    logic             n_ovf;
    logic             r_load_restart;
    logic             n_load_restart;
    logic [POS_W-1:0] r_init;
    logic [POS_W-1:0] n_init;
    logic [POS_W-1:0] r_act;
    logic [POS_W-1:0] n_act;
    logic             r_name_restart;
    logic             n_name_restart;

    logic             in_fire;
    logic             load_wr;
    logic [LEN_W-1:0] ld_len;
    logic [LEN_W-1:0] ld_next;
    logic [POS_W-1:0] ld_init;
    logic [POS_W-1:0] cur;
    logic [POS_W-1:0] raw;
    logic [POS_W-1:0] star_v;
    logic [POS_W-1:0] run_sum;
    logic [POS_W-1:0] closed;
    logic             push;
    t_result          push_data;
    t_result          out_data;
    t_cell_link       links [MAX_PATTERN];

    assign in_fire = i_valid && o_ready;

    // load position: a new pattern starts over from the first cell
    assign ld_len  = r_load_restart ? '0 : r_len;
    assign ld_next = ld_len + LEN_W'(1);
    assign ld_init = r_load_restart ? POS_W'(1) : r_init;
    assign load_wr = in_fire && (i_cmd == CMD_LOAD) && (ld_len < LEN_W'(MAX_PATTERN));

    // start vector for a new name, else the running one
    assign cur = r_name_restart ? r_init : r_act;

    // row of pattern cells
    for (genvar i = 0; i < MAX_PATTERN; i++) begin : g_cell
        logic adv_in;
        if (i == 0) begin : g_first
            assign adv_in = 1'b0;
        end else begin : g_rest
            assign adv_in = links[i-1].adv;
        end

        wnm_cell u_cell (
            .i_clk    (i_clk),
            .i_wr     (load_wr && (ld_len == LEN_W'(i))),
            .i_ch     (i_ch),
            .i_in_use (LEN_W'(i) < r_len),
            .i_cur    (cur[i]),
            .i_adv    (adv_in),
            .o_link   (links[i])
        );

        assign raw[i]    = links[i].nxt;
        assign star_v[i] = links[i].star;
    end

    // raw bit of the final position comes only from advancing out of the last cell
    assign raw[POS_W-1]    = links[MAX_PATTERN-1].adv;
    assign star_v[POS_W-1] = 1'b0;

    // closure over '*' runs: carries ripple through runs of star bits
    assign run_sum = star_v + (raw & star_v);
    assign closed  = raw | (run_sum ^ star_v);

    // beat handling
    always_comb begin
        n_len          = r_len;
        n_ovf          = r_ovf;
        n_load_restart = r_load_restart;
        n_init         = r_init;
        n_act          = r_act;
        n_name_restart = r_name_restart;
        push           = 1'b0;
        if (in_fire) begin
            case (i_cmd)
                CMD_LOAD: begin
                    n_ovf  = r_load_restart ? 1'b0 : r_ovf;
                    n_len  = ld_len;
                    n_init = ld_init;
                    if (ld_len < LEN_W'(MAX_PATTERN)) begin
                        n_len = ld_next;
                        if (ld_init[ld_len] && (i_ch == ANY_RUN)) begin
                            n_init[ld_next] = 1'b1;
                        end
                    end else begin
                        n_ovf = 1'b1;
                    end
                    n_load_restart = i_last;
                    n_name_restart = 1'b1;
                end
                CMD_NAME: begin
                    n_act          = closed;
                    n_name_restart = i_last;
                    push           = i_last;
                end
                default: begin
                end
            endcase
        end
    end

    assign push_data.matched          = closed[r_len];
    assign push_data.pattern_overflow = r_ovf;

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len          <= '0;
            r_ovf          <= 1'b0;
            r_load_restart <= 1'b1;
            r_init         <= POS_W'(1);
            r_act          <= POS_W'(1);
            r_name_restart <= 1'b1;
        end else begin
            r_len          <= n_len;
            r_ovf          <= n_ovf;
            r_load_restart <= n_load_restart;
            r_init         <= n_init;
            r_act          <= n_act;
            r_name_restart <= n_name_restart;
        end
    end

    // result beats
    wnm_out_skid u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_data),
        .o_ready (o_ready),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_data  (out_data)
    );

    assign o_matched          = out_data.matched;
    assign o_pattern_overflow = out_data.pattern_overflow;

    // checks
    `WNM_ASSERT_IMPL(a_stall_has_result, !o_ready, o_valid, "input stalled with no result held")
    `WNM_ASSERT_ALWAYS(a_len_bound, r_len <= LEN_W'(MAX_PATTERN), "pattern length past store")
    `WNM_ASSERT_IMPL(a_ovf_full, r_ovf, r_len == LEN_W'(MAX_PATTERN), "overflow with store not full")
    `WNM_ASSERT_ALWAYS(a_init_origin, r_init[0], "start vector lost position zero")

endmodule

// ----- tb/testbench.sv -----
// self-checking testbench for the wildcard name matcher
`timescale 1ns / 1ps

module testbench;
    import wnm_pkg::*;

    localparam int HOLD_CYCLES = 80;
    localparam int STALL_LIMIT = 2000;
    localparam int PHASE_BEATS = 155;
    localparam int N_ROWS      = 27;

    // one row of the directed table, repeated reps times with last, if set, only on the final beat
    typedef struct packed {
        logic       cmd;
        logic [7:0] ch;
        logic       last;
        logic [7:0] reps;
        logic       typed;
        logic       want_match;
        logic       want_ovf;
    } t_stim_row;

    logic       i_clk   = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_valid = 1'b0;
    logic       i_cmd   = CMD_LOAD;
    logic [7:0] i_ch    = 8'd0;
    logic       i_last  = 1'b0;
    logic       i_ready = 1'b0;
    logic       o_ready;
    logic       o_valid;
    logic       o_matched;
    logic       o_pattern_overflow;

    // matcher state as the testbench sees it
    logic [7:0]       pat_cells [MAX_PATTERN];
    int unsigned      pat_len    = 0;
    logic             pat_ovf    = 1'b0;
    logic             pat_fresh  = 1'b1;
    logic [POS_W-1:0] live_pos   = POS_W'(1);
    logic             name_fresh = 1'b1;

    t_result   verdict_q [$];
    int        err_cnt      = 0;
    int        beats_sent   = 0;
    int        idle_pct     = 0;
    int        stall_pct    = 0;
    int        quiet_cycles = 0;
    bit        hold_req     = 1'b0;
    int        hold_left    = 0;
    t_stim_row dir_tab [N_ROWS];

    wildcard_name_matcher u_top (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_valid            (i_valid),
        .o_ready            (o_ready),
        .i_cmd              (i_cmd),
        .i_ch               (i_ch),
        .i_last             (i_last),
        .o_valid            (o_valid),
        .i_ready            (i_ready),
        .o_matched          (o_matched),
        .o_pattern_overflow (o_pattern_overflow)
    );

    always #4 i_clk = ~i_clk;

    // an active position in front of a '*' cell also activates the one after it
    function automatic logic [POS_W-1:0] close_runs(input logic [POS_W-1:0] v);
        for (int i = 0; i < pat_len; i++) begin
            if (v[i] && pat_cells[i] == ANY_RUN) begin
                v[i+1] = 1'b1;
            end
        end
        return v;
    endfunction

    // advance the matcher state by one beat; returns 1 when the beat yields a verdict
    function automatic bit predict_verdict(input logic cmd, input logic [7:0] ch,
                                           input logic last, output t_result verdict);
        logic [POS_W-1:0] cur;
        logic [POS_W-1:0] nxt;
        verdict = '0;
        if (cmd == CMD_LOAD) begin
            if (pat_fresh) begin
                pat_len = 0;
                pat_ovf = 1'b0;
            end
            if (pat_len < MAX_PATTERN) begin
                pat_cells[pat_len] = ch;
                pat_len++;
            end else begin
                pat_ovf = 1'b1;
            end
            pat_fresh  = last;
            name_fresh = 1'b1;
            return 1'b0;
        end
        cur = name_fresh ? close_runs(POS_W'(1)) : live_pos;
        nxt = '0;
        for (int i = 0; i < pat_len; i++) begin
            if (cur[i]) begin
                if (pat_cells[i] == ANY_RUN) begin
                    nxt[i] = 1'b1;
                end else if (pat_cells[i] == ANY_ONE || pat_cells[i] == ch) begin
                    nxt[i+1] = 1'b1;
                end
            end
        end
        live_pos   = close_runs(nxt);
        name_fresh = last;
        verdict.matched          = live_pos[pat_len];
        verdict.pattern_overflow = pat_ovf;
        return last;
    endfunction

    task automatic report_mismatch(input string what, input logic got, input logic want);
        $display("mismatch at %0t: %s got %0b want %0b", $realtime, what, got, want);
        err_cnt++;
    endtask

    // offer one beat from a falling edge, hold it until accepted, then predict
    task automatic send_beat(input logic cmd, input logic [7:0] ch, input logic last,
                             input logic typed, input t_result typed_want);
        int      gap;
        t_result verdict;
        gap = 0;
        while ($urandom_range(0, 99) < idle_pct && gap < 40) gap++;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_cmd   <= cmd;
        i_ch    <= ch;
        i_last  <= last;
        do @(posedge i_clk); while (!o_ready);
        if (predict_verdict(cmd, ch, last, verdict)) begin
            verdict_q.push_back(typed ? typed_want : verdict);
        end
        beats_sent++;
        @(negedge i_clk);
    endtask

    // mostly a pattern followed by names built to fit it, with some noise beats
    task automatic send_random(input int goal);
        logic [7:0] pat [$];
        logic [7:0] nm [$];
        logic [7:0] b;
        int         plen;
        while (beats_sent < goal) begin
            if ($urandom_range(0, 99) < 80) begin
                pat.delete();
                plen = ($urandom_range(0, 99) < 8) ? $urandom_range(28, 40)
                                                   : $urandom_range(1, 8);
                repeat (plen) begin
                    case ($urandom_range(0, 9))
                        0, 1:    b = ANY_RUN;
                        2:       b = ANY_ONE;
                        9:       b = 8'($urandom_range(0, 255));
                        default: b = 8'h61 + 8'($urandom_range(0, 2));
                    endcase
                    pat.push_back(b);
                end
                foreach (pat[j]) send_beat(CMD_LOAD, pat[j], j == pat.size() - 1, 1'b0, '0);
                repeat ($urandom_range(1, 4)) begin
                    nm.delete();
                    foreach (pat[j]) begin
                        if (pat[j] == ANY_RUN) begin
                            repeat ($urandom_range(0, 3))
                                nm.push_back(8'h61 + 8'($urandom_range(0, 3)));
                        end else if (pat[j] == ANY_ONE) begin
                            nm.push_back(($urandom_range(0, 3) == 0)
                                         ? 8'($urandom_range(0, 255))
                                         : 8'h61 + 8'($urandom_range(0, 3)));
                        end else begin
                            nm.push_back(pat[j]);
                        end
                    end
                    // break some names so both verdicts show up
                    if (nm.size() > 0 && $urandom_range(0, 99) < 35) begin
                        nm[$urandom_range(0, nm.size() - 1)] = 8'h61 + 8'($urandom_range(0, 3));
                    end
                    if (nm.size() == 0 || $urandom_range(0, 99) < 10) begin
                        nm.push_back(8'h61 + 8'($urandom_range(0, 3)));
                    end
                    foreach (nm[j]) send_beat(CMD_NAME, nm[j], j == nm.size() - 1, 1'b0, '0);
                end
            end else begin
                repeat ($urandom_range(1, 6)) begin
                    send_beat(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                              $urandom_range(0, 3) == 0, 1'b0, '0);
                end
            end
        end
    endtask

    // receiver: random stalls, or a long hold-off when asked
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            i_ready   <= 1'b0;
        end else if (hold_req) begin
            hold_req = 1'b0;
            hold_left <= HOLD_CYCLES;
            i_ready   <= 1'b0;
        end else begin
            i_ready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    // compare each result beat with the oldest pending verdict
    always @(posedge i_clk) begin : result_check
        t_result want;
        if (i_rst_n && o_valid && i_ready) begin
            if (verdict_q.size() == 0) begin
                report_mismatch("result with none pending, matched", o_matched, 1'bx);
            end else begin
                want = verdict_q.pop_front();
                if (o_matched !== want.matched) begin
                    report_mismatch("matched", o_matched, want.matched);
                end
                if (o_pattern_overflow !== want.pattern_overflow) begin
                    report_mismatch("pattern_overflow", o_pattern_overflow, want.pattern_overflow);
                end
            end
        end
    end

    // watchdog on cycles with no beat moving on either side
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("wildcard_name_matcher verification failed");
            $finish;
        end
    end

    initial begin
        // cmd, ch, last, reps, typed, matched, overflow
        dir_tab = '{
            '{CMD_NAME, 8'h41,   1'b1, 8'd1,  1'b1, 1'b0, 1'b0},  // empty pattern never matches
            '{CMD_LOAD, 8'h61,   1'b0, 8'd1,  1'b0, 1'b0, 1'b0},
            '{CMD_LOAD, ANY_ONE, 1'b0, 8'd1,  1'b0, 1'b0, 1'b0},
            '{CMD_LOAD, ANY_RUN, 1'b1, 8'd1,  1'b0, 1'b0, 1'b0},
            '{CMD_NAME, 8'h61,   1'b0, 8'd1,  1'b0, 1'b0, 1'b0},
            '{CMD_NAME, 8'h62,   1'b1, 8'd1,  1'b1, 1'b1, 1'b0},  // "ab" fits a?*
            '{CMD_NAME, 8'h61,   1'b1, 8'd1,  1'b1, 1'b0, 1'b0},  // "a" is one short
            '{CMD_NAME, 8'h62,   1'b0, 8'd1,  1'b0, 1'b0, 1'b0},
            '{CMD_NAME, 8'h61,   1'b0, 8'd1,  1'b0, 1'b0, 1'b0},
            '{CMD_NAME, 8'h78,   1'b1, 8'd1,  1'b1, 1'b0, 1'b0},
            '{CMD_LOAD, 8'h00,   1'b0, 8'd1,  1'b0, 1'b0, 1'b0},  // byte extremes
            '{CMD_LOAD, 8'hff,   1'b1, 8'd1,  1'b0, 1'b0, 1'b0},
            '{CMD_NAME, 8'h00,   1'b0, 8'd1,  1'b0, 1'b0, 1'b0},
            '{CMD_NAME, 8'hff,   1'b1, 8'd1,  1'b1, 1'b1, 1'b0},
            '{CMD_NAME, 8'hff,   1'b1, 8'd1,  1'b1, 1'b0, 1'b0},
            '{CMD_LOAD, 8'h78,   1'b0, 8'd1,  1'b0, 1'b0, 1'b0},  // pattern left open
            '{CMD_NAME, 8'h78,   1'b1, 8'd1,  1'b0, 1'b0, 1'b0},
            '{CMD_LOAD, 8'h79,   1'b1, 8'd1,  1'b0, 1'b0, 1'b0},
            '{CMD_NAME, 8'h78,   1'b0, 8'd1,  1'b0, 1'b0, 1'b0},
            '{CMD_NAME, 8'h79,   1'b1, 8'd1,  1'b0, 1'b0, 1'b0},
            '{CMD_NAME, 8'h78,   1'b0, 8'd1,  1'b0, 1'b0, 1'b0},  // name cut by a pattern load
            '{CMD_LOAD, 8'h71,   1'b1, 8'd1,  1'b0, 1'b0, 1'b0},
            '{CMD_NAME, 8'h71,   1'b1, 8'd1,  1'b0, 1'b0, 1'b0},
            '{CMD_LOAD, ANY_RUN, 1'b1, 8'd40, 1'b0, 1'b0, 1'b0},  // too long, gets truncated
            '{CMD_NAME, 8'hff,   1'b1, 8'd1,  1'b1, 1'b1, 1'b1},
            '{CMD_LOAD, 8'h6b,   1'b1, 8'd1,  1'b0, 1'b0, 1'b0},  // new pattern clears the flag
            '{CMD_NAME, 8'h6b,   1'b1, 8'd1,  1'b1, 1'b1, 1'b0}
        };

        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed table
        for (int r = 0; r < N_ROWS; r++) begin
            for (int k = 0; k < dir_tab[r].reps; k++) begin
                send_beat(dir_tab[r].cmd, dir_tab[r].ch,
                          dir_tab[r].last && (k == dir_tab[r].reps - 1), dir_tab[r].typed,
                          {dir_tab[r].want_match, dir_tab[r].want_ovf});
            end
        end

        // long receiver hold while short names keep coming, so the input backs up
        hold_req = 1'b1;
        repeat (6) send_beat(CMD_NAME, 8'h61 + 8'($urandom_range(0, 3)), 1'b1, 1'b0, '0);
        send_random(beats_sent + PHASE_BEATS);

        // sender pauses until every pending result is out
        i_valid <= 1'b0;
        do @(negedge i_clk); while (verdict_q.size() != 0);

        idle_pct  = 64;
        stall_pct = 0;
        send_random(beats_sent + PHASE_BEATS);

        idle_pct  = 0;
        stall_pct = 64;
        send_random(beats_sent + PHASE_BEATS);

        idle_pct  = 13;
        stall_pct = 13;
        send_random(beats_sent + PHASE_BEATS);

        // drain
        i_valid   <= 1'b0;
        stall_pct = 0;
        while (verdict_q.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (err_cnt == 0) begin
            $display("wildcard_name_matcher verification clean");
        end else begin
            $display("wildcard_name_matcher verification failed");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
+incdir+rtl
rtl/wnm_pkg.sv
rtl/wnm_cell.sv
rtl/wnm_out_skid.sv
rtl/wildcard_name_matcher.sv
tb/testbench.sv
